// ----- rtl/esc_pkg.sv -----
`default_nettype none

package esc_pkg;

  // mode codes (code 7 is unused and falls back to wait-neutral)
  localparam logic [2:0] MODE_BOOT  = 3'd0;
  localparam logic [2:0] MODE_WAITN = 3'd1;
  localparam logic [2:0] MODE_READY = 3'd2;
  localparam logic [2:0] MODE_FWD   = 3'd3;
  localparam logic [2:0] MODE_BRAKE = 3'd4;
  localparam logic [2:0] MODE_REV   = 3'd5;
  localparam logic [2:0] MODE_FAULT = 3'd6;

  // motor controller states
  localparam logic [2:0] MS_IDLE  = 3'd0;
  localparam logic [2:0] MS_START = 3'd1;
  localparam logic [2:0] MS_RUN   = 3'd2;
  localparam logic [2:0] MS_FNOW  = 3'd3;
  localparam logic [2:0] MS_FOVER = 3'd4;

  // rev-up direction codes
  localparam logic [1:0] REVUP_NONE = 2'd0;
  localparam logic [1:0] REVUP_FWD  = 2'd1;
  localparam logic [1:0] REVUP_REV  = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TELEM      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TORQUE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WRONG_DIR  = 3'd4;

  // configuration reset values
  localparam logic [14:0] DEADBAND_RESET   = 15'd655;
  localparam logic [15:0] TIMEOUT_RESET    = 16'd500;
  localparam logic [15:0] TELEM_RESET      = 16'd100;
  localparam logic [14:0] MAX_TORQUE_RESET = 15'd7000;
  localparam logic [14:0] WRONG_DIR_RESET  = 15'd50;

  // full-scale command, torque divisor (2^15 - 1)
  localparam logic [14:0] FULL_SCALE = 15'h7FFF;

  typedef struct packed {
    logic               fresh_cmd;
    logic signed [15:0] cmd_raw;
    logic        [2:0]  motor_state;
    logic signed [15:0] speed_rpm;
    logic        [15:0] fault_bits;
    logic               start_granted;
  } tick_t;

  typedef struct packed {
    logic        [2:0]  mode;
    logic               stop_req;
    logic               start_req;
    logic               ack_req;
    logic        [1:0]  revup_dir;
    logic               torque_valid;
    logic signed [15:0] torque_ma;
    logic               telemetry_due;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/esc_stream_if.sv -----
`default_nettype none

interface esc_tick_if;
  logic           valid;
  logic           ready;
  esc_pkg::tick_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface esc_result_if;
  logic             valid;
  logic             ready;
  esc_pkg::result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/esc_drive_mode_sequencer_core.sv -----
`default_nettype none

// Drive-mode sequencer for a sensorless ESC, one tick transaction per 1 kHz control
// period. Each tick transaction updates the seven-state drive mode, the command-silence
// counter and the telemetry divider, and yields exactly one result transaction with the
// new mode, stop/start/ack requests, rev-up direction, torque target and telemetry strobe.
// Throughput is one transaction per clock while result.ready does not stall it; the input
// stage holds the mode decision and the 16x15 command-times-max-torque multiplier, the
// output stage holds the divide-by-32767 reduction (shift, add and two compares).
// A two-deep register pipeline separates tick and result sides, so a tick is taken
// while a result waits, as long as the input stage is empty. Configuration registers
// are written through cfg_we/cfg_index/cfg_data at any edge; indexes past the register
// list are ignored. Write them only while the pipeline is empty.

module esc_drive_mode_sequencer_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  esc_tick_if.sink                              tick,
  esc_result_if.source                          result,
  input  wire logic                             cfg_we,
  input  wire logic [esc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [esc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // input-stage register: decisions plus the raw torque product
  typedef struct packed {
    esc_pkg::result_t res;
    logic [29:0]      prod_mag;
    logic             prod_neg;
  } stage_t;

  // configuration
  logic [14:0] deadband_raw;
  logic [15:0] timeout_ticks;
  logic [15:0] telemetry_period;
  logic [14:0] max_torque_ma;
  logic [14:0] wrong_dir_rpm;

  // sequencer state
  logic [2:0]  mode_reg;
  logic [15:0] silence_count;
  logic [15:0] telemetry_count;

  // pipeline
  logic   s1_valid;
  stage_t s1;
  logic   s2_valid;
  esc_pkg::result_t s2;

  logic adv2;
  logic accept;

  assign adv2       = !s2_valid || result.ready;
  assign tick.ready = !s1_valid || adv2;
  assign accept     = tick.valid && tick.ready;

  // ---------------- decision logic on the incoming tick ----------------
  logic [15:0] raw_u;
  logic [15:0] cmd_mag;
  logic        pos, neg, neutral, running;
  logic [15:0] spd_u;
  logic [15:0] spd_mag;
  logic        spd_over_pos, spd_over_neg;
  logic [15:0] silence_next;
  logic        cmd_stale;
  logic [15:0] telem_inc;
  logic [15:0] telemetry_next;
  logic        due;
  logic [29:0] prod_full;
  logic [2:0]  m;
  logic        stop, start, ack, tvalid;
  logic [1:0]  revup;
  logic        fwd, against, wrong;

  assign raw_u   = tick.payload.cmd_raw;
  assign cmd_mag = raw_u[15] ? (~raw_u + 16'd1) : raw_u;
  // signed compares against a nonnegative deadband
  assign pos     = !raw_u[15] && (raw_u[14:0] > deadband_raw);
  assign neg     = raw_u[15] && (cmd_mag > {1'b0, deadband_raw});
  assign neutral = !pos && !neg;
  assign running = (tick.payload.motor_state == esc_pkg::MS_RUN) ||
                   (tick.payload.motor_state == esc_pkg::MS_START);

  assign spd_u        = tick.payload.speed_rpm;
  assign spd_mag      = spd_u[15] ? (~spd_u + 16'd1) : spd_u;
  assign spd_over_pos = !spd_u[15] && (spd_u[14:0] > wrong_dir_rpm);
  assign spd_over_neg = spd_u[15] && (spd_mag > {1'b0, wrong_dir_rpm});

  // silence counter saturates at the timeout
  always_comb begin
    if (tick.payload.fresh_cmd) begin
      silence_next = '0;
    end else if (silence_count < timeout_ticks) begin
      silence_next = silence_count + 16'd1;
    end else begin
      silence_next = silence_count;
    end
  end
  assign cmd_stale = silence_next >= timeout_ticks;

  // telemetry divider; a zero period strobes every tick
  assign telem_inc      = telemetry_count + 16'd1;
  assign due            = telem_inc >= telemetry_period;
  assign telemetry_next = due ? 16'd0 : telem_inc;

  // |raw| <= 2^15 and max torque < 2^15, so the product stays below 2^30
  assign prod_full = 30'(cmd_mag) * 30'(max_torque_ma);

  always_comb begin
    m       = mode_reg;
    stop    = 1'b0;
    start   = 1'b0;
    ack     = 1'b0;
    tvalid  = 1'b0;
    revup   = esc_pkg::REVUP_NONE;
    fwd     = 1'b0;
    against = 1'b0;
    wrong   = 1'b0;

    // fault entry overrides, fault rules then run in the same tick
    if (((tick.payload.fault_bits != 16'd0) ||
         (tick.payload.motor_state == esc_pkg::MS_FNOW) ||
         (tick.payload.motor_state == esc_pkg::MS_FOVER)) &&
        (m != esc_pkg::MODE_FAULT)) begin
      stop = 1'b1;
      m    = esc_pkg::MODE_FAULT;
    end

    case (m)
      esc_pkg::MODE_BOOT: begin
        m = esc_pkg::MODE_WAITN;
      end
      esc_pkg::MODE_WAITN: begin
        if (neutral) m = esc_pkg::MODE_READY;
      end
      esc_pkg::MODE_READY: begin
        if (tick.payload.fresh_cmd && (pos || neg)) begin
          start = 1'b1;
          if (tick.payload.start_granted) begin
            revup = pos ? esc_pkg::REVUP_FWD : esc_pkg::REVUP_REV;
            m     = pos ? esc_pkg::MODE_FWD : esc_pkg::MODE_REV;
          end
        end
      end
      esc_pkg::MODE_FWD, esc_pkg::MODE_REV: begin
        fwd     = (m == esc_pkg::MODE_FWD);
        against = fwd ? neg : pos;
        wrong   = fwd ? spd_over_neg : spd_over_pos;
        if (cmd_stale || neutral) begin
          if (running) stop = 1'b1;
          m = esc_pkg::MODE_READY;
        end else if (against) begin
          if (running) stop = 1'b1;
          m = esc_pkg::MODE_BRAKE;
        end else if (tick.payload.motor_state == esc_pkg::MS_RUN) begin
          if (wrong) begin
            stop = 1'b1;
            m    = esc_pkg::MODE_READY;
          end else begin
            tvalid = 1'b1;
          end
        end else if (tick.payload.motor_state == esc_pkg::MS_IDLE) begin
          if (tick.payload.fresh_cmd) begin
            start = 1'b1;
            if (tick.payload.start_granted) begin
              revup = fwd ? esc_pkg::REVUP_FWD : esc_pkg::REVUP_REV;
            end
          end
        end
      end
      esc_pkg::MODE_BRAKE: begin
        if (tick.payload.motor_state == esc_pkg::MS_IDLE) begin
          if (tick.payload.fresh_cmd && (neg || pos)) begin
            start = 1'b1;
            if (tick.payload.start_granted) begin
              revup = neg ? esc_pkg::REVUP_REV : esc_pkg::REVUP_FWD;
              m     = neg ? esc_pkg::MODE_REV : esc_pkg::MODE_FWD;
            end
          end else begin
            m = esc_pkg::MODE_READY;
          end
        end
      end
      esc_pkg::MODE_FAULT: begin
        if (tick.payload.motor_state == esc_pkg::MS_FOVER) begin
          ack = 1'b1;
          if (pos || neg) begin
            start = 1'b1;
            if (tick.payload.start_granted) begin
              revup = pos ? esc_pkg::REVUP_FWD : esc_pkg::REVUP_REV;
            end
            m = pos ? esc_pkg::MODE_FWD : esc_pkg::MODE_REV;
          end else begin
            m = esc_pkg::MODE_WAITN;
          end
        end
      end
      default: begin
        m = esc_pkg::MODE_WAITN;
      end
    endcase
  end

  // ---------------- output stage: divide by 32767 ----------------
  // p = q0*2^15 + lo = q0*32767 + (q0 + lo); remainder term r0 < 2*32767 + 1
  logic [14:0] q0;
  logic [15:0] r0;
  logic [15:0] quot;
  logic [15:0] torque_next;
  esc_pkg::result_t s2_next;

  assign q0   = s1.prod_mag[29:15];
  assign r0   = 16'(q0) + 16'(s1.prod_mag[14:0]);
  assign quot = 16'(q0) + 16'(r0 >= {1'b0, esc_pkg::FULL_SCALE})
                        + 16'(r0 >= {esc_pkg::FULL_SCALE, 1'b0});
  assign torque_next = !s1.res.torque_valid ? 16'd0 :
                       s1.prod_neg ? (~quot + 16'd1) : quot;

  always_comb begin
    s2_next           = s1.res;
    s2_next.torque_ma = torque_next;
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      deadband_raw     <= esc_pkg::DEADBAND_RESET;
      timeout_ticks    <= esc_pkg::TIMEOUT_RESET;
      telemetry_period <= esc_pkg::TELEM_RESET;
      max_torque_ma    <= esc_pkg::MAX_TORQUE_RESET;
      wrong_dir_rpm    <= esc_pkg::WRONG_DIR_RESET;
      mode_reg         <= esc_pkg::MODE_BOOT;
      silence_count    <= '0;
      telemetry_count  <= '0;
      s1_valid         <= 1'b0;
      s2_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          esc_pkg::CFG_DEADBAND:   deadband_raw     <= cfg_data[14:0];
          esc_pkg::CFG_TIMEOUT:    timeout_ticks    <= cfg_data;
          esc_pkg::CFG_TELEM:      telemetry_period <= cfg_data;
          esc_pkg::CFG_MAX_TORQUE: max_torque_ma    <= cfg_data[14:0];
          esc_pkg::CFG_WRONG_DIR:  wrong_dir_rpm    <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (accept) begin
        mode_reg        <= m;
        silence_count   <= silence_next;
        telemetry_count <= telemetry_next;
      end
      if (tick.ready) s1_valid <= accept;
      if (adv2)       s2_valid <= s1_valid;
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (accept) begin
      s1.res.mode          <= m;
      s1.res.stop_req      <= stop;
      s1.res.start_req     <= start;
      s1.res.ack_req       <= ack;
      s1.res.revup_dir     <= revup;
      s1.res.torque_valid  <= tvalid;
      s1.res.torque_ma     <= '0;
      s1.res.telemetry_due <= due;
      s1.prod_mag          <= prod_full;
      s1.prod_neg          <= raw_u[15];
    end
    if (adv2 && s1_valid) begin
      s2 <= s2_next;
    end
  end

  assign result.valid   = s2_valid;
  assign result.payload = s2;

  // ---------------- assertions ----------------
  a_reset_empty: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");

  a_torque_mode: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.payload.torque_valid) |->
      (result.payload.mode == esc_pkg::MODE_FWD || result.payload.mode == esc_pkg::MODE_REV))
    else $error("torque target outside forward/reverse");

  a_revup_start: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.payload.revup_dir != esc_pkg::REVUP_NONE) |->
      result.payload.start_req)
    else $error("rev-up without start request");

  a_torque_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.payload.torque_valid) |-> (result.payload.torque_ma == 16'sd0))
    else $error("torque nonzero without torque_valid");

  a_pipe_fill: assert property (@(posedge clk) disable iff (rst)
    (accept && !s1_valid && !s2_valid) |=> (s1_valid && !result.valid))
    else $error("accepted transaction lost from input stage");

endmodule

`default_nettype wire
